// ----- rtl/core/fcrs_pkg.sv -----
// Shared types, constants and helpers for the filled-circle row span block.
// No dependencies; every other file in rtl/core imports this package.

package fcrs_pkg;

  // Field and register widths
  localparam int ROW_W   = 12;   // row index and span columns
  localparam int DIM_W   = 13;   // image dimensions and centre offsets
  localparam int RADI_W  = 12;   // circle radius
  localparam int INDEX_W = 3;    // configuration register index

  // Largest image dimension honored; larger values saturate to it
  localparam logic [DIM_W-1:0] DIM_MAX = 13'd4096;

  // Internal arithmetic widths, half-pixel units
  localparam int COORD_W    = 16;  // doubled coordinates (x2, y2, dy, band edges)
  localparam int SQ_W       = 28;  // squares of doubled coordinates
  localparam int RAD_W      = 26;  // radicand, bounded by (2r)^2
  localparam int ROOT_STEPS = RAD_W / 2;
  localparam int ROOT_W     = ROOT_STEPS;
  localparam int REM_W      = ROOT_W + 2;
  localparam int POS_W      = 18;  // rounded span ends before clamping

  localparam logic signed [POS_W-1:0] POS_ONE  = 18'sd1;
  localparam logic signed [POS_W-1:0] POS_ZERO = 18'sd0;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [INDEX_W-1:0] {
    CFG_CENTER_X     = 3'd0,
    CFG_CENTER_Y     = 3'd1,
    CFG_RADIUS       = 3'd2,
    CFG_IMAGE_WIDTH  = 3'd3,
    CFG_IMAGE_HEIGHT = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic signed [DIM_W-1:0] center_x;
    logic signed [DIM_W-1:0] center_y;
    logic [RADI_W-1:0]       radius;
    logic [DIM_W-1:0]        width;
    logic [DIM_W-1:0]        height;
  } cfg_t;

  // One classified request as handed from front to back
  typedef struct packed {
    logic                      ok;        // in band with non-negative radicand
    logic [RAD_W-1:0]          rad;
    logic signed [COORD_W-1:0] x2;        // doubled centre column
    logic                      nonneg_p;  // x2 + sqrt(rad) >= 0
    logic                      nonneg_m;  // x2 - sqrt(rad) >= 0
  } queue_entry_t;

  // One stage of the square-root pipe
  typedef struct packed {
    logic                      ok;
    logic signed [COORD_W-1:0] x2;
    logic                      nonneg_p;
    logic                      nonneg_m;
    logic [RAD_W-1:0]          rad;   // radicand digits still to consume
    logic [ROOT_W-1:0]         q;     // partial root
    logic [REM_W-1:0]          rem;   // partial remainder
  } root_t;

  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
    return (v > DIM_MAX) ? DIM_MAX : v;
  endfunction

  // One digit-pair step of the restoring square root
  function automatic root_t root_step(input root_t s);
    root_t             n;
    logic [REM_W-1:0]  cur;
    logic [REM_W-1:0]  trial;
    n     = s;
    cur   = {s.rem[REM_W-3:0], s.rad[RAD_W-1 -: 2]};
    trial = {s.q, 2'b01};
    n.rad = {s.rad[RAD_W-3:0], 2'b00};
    if (cur >= trial) begin
      n.rem = cur - trial;
      n.q   = {s.q[ROOT_W-2:0], 1'b1};
    end else begin
      n.rem = cur;
      n.q   = {s.q[ROOT_W-2:0], 1'b0};
    end
    return n;
  endfunction

endpackage

// ----- rtl/core/fcrs_front.sv -----
// Front of the row span block: accepts row requests, tests the row band and
// forms the radicand and sign flags in three stages. Depends on fcrs_pkg.

module fcrs_front (
  input  logic                           clk,
  input  logic                           rst,
  input  fcrs_pkg::cfg_t                 cfg,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [fcrs_pkg::ROW_W-1:0]     row_index,
  output logic                           push,
  output fcrs_pkg::queue_entry_t         push_data,
  input  logic                           queue_full
);
  import fcrs_pkg::*;

  logic                      en;
  logic [DIM_W-1:0]          w_s;
  logic [DIM_W-1:0]          h_s;
  logic signed [COORD_W-1:0] x2;
  logic signed [COORD_W-1:0] y2;
  logic signed [COORD_W-1:0] r2;
  logic signed [COORD_W-1:0] dy;

  logic                      s1_valid;
  logic [ROW_W-1:0]          s1_y;
  logic signed [COORD_W-1:0] s1_dy;
  logic signed [COORD_W-1:0] s1_lo2;
  logic signed [COORD_W-1:0] s1_hi2;
  logic signed [COORD_W-1:0] s1_x2;

  logic signed [COORD_W-1:0]   top;
  logic signed [COORD_W-1:0]   hi_round;
  logic signed [COORD_W-1:0]   bot;
  logic signed [COORD_W-1:0]   h2;
  logic signed [COORD_W-1:0]   hm1;
  logic signed [COORD_W-1:0]   y_s;
  logic signed [2*COORD_W-1:0] dy_sq_full;
  logic signed [2*COORD_W-1:0] a_sq_full;
  logic [RAD_W-1:0]            rr4;

  logic                      s2_valid;
  logic                      s2_inband;
  logic [SQ_W-1:0]           s2_dy_sq;
  logic [SQ_W-1:0]           s2_a_sq;
  logic [RAD_W-1:0]          s2_rr4;
  logic signed [COORD_W-1:0] s2_x2;

  logic signed [SQ_W:0]      rad_s;
  logic                      rad_ge;
  logic                      rad_le;

  logic                      s3_valid;
  queue_entry_t              s3_entry;

  // Hold the whole front while the last stage cannot enter the queue
  assign en       = !(s3_valid && queue_full);
  assign in_stall = !en;
  assign push     = s3_valid && en;
  assign push_data = s3_entry;

  // Stage 1: doubled centre, band edges and row distance
  always_comb begin
    w_s = sat_dim(cfg.width);
    h_s = sat_dim(cfg.height);
    x2  = (COORD_W'(cfg.center_x) <<< 1) + $signed(COORD_W'(w_s));
    y2  = (COORD_W'(cfg.center_y) <<< 1) + $signed(COORD_W'(h_s));
    r2  = $signed(COORD_W'({cfg.radius, 1'b0}));
    dy  = $signed(COORD_W'({row_index, 1'b0})) - y2;
  end

  // Stage 2: band test and squares
  always_comb begin
    h2  = $signed(COORD_W'({h_s, 1'b0}));
    hm1 = $signed(COORD_W'(h_s)) - 16'sd1;
    y_s = $signed(COORD_W'(s1_y));
    top = (s1_lo2 > 16'sd0) ? ((s1_lo2 + 16'sd1) >>> 1) : 16'sd0;
    if (s1_hi2 >= 16'sd0) begin
      hi_round = (s1_hi2 + 16'sd1) >>> 1;
    end else begin
      hi_round = -((16'sd1 - s1_hi2) >>> 1);
    end
    bot = ((s1_hi2 < h2) && (hi_round < hm1)) ? hi_round : hm1;
    dy_sq_full = s1_dy * s1_dy;
    a_sq_full  = s1_x2 * s1_x2;
    rr4 = RAD_W'({cfg.radius, 1'b0}) * RAD_W'({cfg.radius, 1'b0});
  end

  // Stage 3: radicand and the sign of each span end
  always_comb begin
    rad_s  = $signed({1'b0, SQ_W'(s2_rr4)}) - $signed({1'b0, s2_dy_sq});
    rad_ge = !rad_s[SQ_W] && (rad_s[SQ_W-1:0] >= s2_a_sq);
    rad_le = rad_s[SQ_W] || (s2_a_sq >= rad_s[SQ_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_y   <= row_index;
      s1_dy  <= dy;
      s1_lo2 <= y2 - r2;
      s1_hi2 <= y2 + r2;
      s1_x2  <= x2;

      s2_inband <= (y_s >= top) && (y_s <= bot);
      s2_dy_sq  <= dy_sq_full[SQ_W-1:0];
      s2_a_sq   <= a_sq_full[SQ_W-1:0];
      s2_rr4    <= rr4;
      s2_x2     <= s1_x2;

      s3_entry.ok       <= s2_inband && !rad_s[SQ_W];
      s3_entry.rad      <= rad_s[RAD_W-1:0];
      s3_entry.x2       <= s2_x2;
      s3_entry.nonneg_p <= !s2_x2[COORD_W-1] || rad_ge;
      s3_entry.nonneg_m <= !s2_x2[COORD_W-1] && rad_le;
    end
  end

endmodule

// ----- rtl/core/fcrs_queue.sv -----
// Short request queue between the front and the back of the row span block.
// Depends on fcrs_pkg for the entry type and depth.

module fcrs_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  fcrs_pkg::queue_entry_t push_data,
  output logic                   full,
  input  logic                   pop,
  output fcrs_pkg::queue_entry_t pop_data,
  output logic                   empty
);
  import fcrs_pkg::*;

  queue_entry_t        slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign full     = (count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- rtl/core/fcrs_back.sv -----
// Back of the row span block: pipelined square root, exact rounding of both
// span ends, clipping and the output register. Depends on fcrs_pkg.

module fcrs_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [fcrs_pkg::DIM_W-1:0]    image_width,
  input  fcrs_pkg::queue_entry_t        pop_data,
  input  logic                          empty,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          row_hit,
  output logic [fcrs_pkg::ROW_W-1:0]    span_first,
  output logic [fcrs_pkg::ROW_W-1:0]    span_last
);
  import fcrs_pkg::*;

  logic                    en;
  root_t                   seed;
  root_t                   pipe [ROOT_STEPS];
  logic [ROOT_STEPS-1:0]   pipe_valid;
  root_t                   fin;

  logic signed [POS_W-1:0] a;
  logic signed [POS_W-1:0] qs;
  logic signed [POS_W-1:0] inx;
  logic signed [POS_W-1:0] first_v;
  logic signed [POS_W-1:0] last_v;

  logic                    rnd_valid;
  logic                    rnd_ok;
  logic signed [POS_W-1:0] rnd_first;
  logic signed [POS_W-1:0] rnd_last;

  logic [DIM_W-1:0]        w_s;
  logic signed [POS_W-1:0] wm1;
  logic signed [POS_W-1:0] first_c;
  logic signed [POS_W-1:0] last_c;
  logic                    hit;

  // Advance the whole back pipe unless a finished result is held
  assign en  = !out_valid || !out_stall;
  assign pop = en && !empty;

  always_comb begin
    seed          = '0;
    seed.ok       = pop_data.ok;
    seed.x2       = pop_data.x2;
    seed.nonneg_p = pop_data.nonneg_p;
    seed.nonneg_m = pop_data.nonneg_m;
    seed.rad      = pop_data.rad;
  end

  // Round (x2 +/- sqrt(rad)) / 2 with ties away from zero
  always_comb begin
    fin = pipe[ROOT_STEPS-1];
    a   = POS_W'(fin.x2);
    qs  = $signed(POS_W'(fin.q));
    inx = $signed(POS_W'(fin.rem != '0));
    if (fin.nonneg_p) begin
      last_v = (a + POS_ONE + qs) >>> 1;
    end else begin
      last_v = -((POS_ONE - a - qs - inx) >>> 1);
    end
    if (fin.nonneg_m) begin
      first_v = (a + POS_ONE - qs - inx) >>> 1;
    end else begin
      first_v = -((POS_ONE - a + qs) >>> 1);
    end
  end

  // Clip to the image columns
  always_comb begin
    w_s     = sat_dim(image_width);
    wm1     = $signed(POS_W'(w_s)) - POS_ONE;
    first_c = (rnd_first < POS_ZERO) ? POS_ZERO : rnd_first;
    last_c  = (rnd_last > wm1) ? wm1 : rnd_last;
    hit     = rnd_ok && (first_c <= last_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= '0;
      rnd_valid  <= 1'b0;
      out_valid  <= 1'b0;
    end else if (en) begin
      pipe_valid <= {pipe_valid[ROOT_STEPS-2:0], !empty};
      rnd_valid  <= pipe_valid[ROOT_STEPS-1];
      out_valid  <= rnd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pipe[0] <= root_step(seed);
      for (int i = 1; i < ROOT_STEPS; i++) begin
        pipe[i] <= root_step(pipe[i-1]);
      end
      rnd_ok     <= fin.ok;
      rnd_first  <= first_v;
      rnd_last   <= last_v;
      row_hit    <= hit;
      span_first <= hit ? first_c[ROW_W-1:0] : '0;
      span_last  <= hit ? last_c[ROW_W-1:0] : '0;
    end
  end

endmodule

// ----- rtl/core/filled_circle_row_span.sv -----
// Top level of the filled-circle row span block: configuration registers,
// front, request queue and back. Depends on fcrs_pkg, fcrs_front,
// fcrs_queue and fcrs_back.
//
// Usage:
//   Set the circle centre (offsets from the image centre), radius and image
//   size through the write port (wr_en, wr_index, wr_data) while no request
//   is in flight. Each request on the input channel (in_valid, in_stall,
//   row_index) yields exactly one result on the output channel (out_valid,
//   out_stall, row_hit, span_first, span_last): the clipped pixel span of the
//   circle on that row, or row_hit low with zero columns.
//   From acceptance to out_valid a request passes three front stages, the
//   queue slot, thirteen square-root stages (one radicand digit pair each),
//   a rounding stage and the output register.
//   Throughput is one request per cycle when nothing stalls; the square-root
//   pipe and the multipliers in the front are each used once per request.
//   While out_stall is high with a result held, the back holds and the
//   four-entry queue absorbs the front; in_stall rises only when the queue is
//   full and the front's last stage holds a request.
//   Reset empties the pipes and queue and restores the register defaults:
//   offsets 0, radius 0, width 640, height 480.

module filled_circle_row_span (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [fcrs_pkg::INDEX_W-1:0]  wr_index,
  input  logic [fcrs_pkg::DIM_W-1:0]    wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [fcrs_pkg::ROW_W-1:0]    row_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          row_hit,
  output logic [fcrs_pkg::ROW_W-1:0]    span_first,
  output logic [fcrs_pkg::ROW_W-1:0]    span_last
);
  import fcrs_pkg::*;

  cfg_t         cfg;
  logic         push;
  queue_entry_t push_data;
  logic         queue_full;
  logic         pop;
  queue_entry_t pop_data;
  logic         queue_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_x <= '0;
      cfg.center_y <= '0;
      cfg.radius   <= '0;
      cfg.width    <= 13'd640;
      cfg.height   <= 13'd480;
    end else if (wr_en) begin
      case (cfg_index_t'(wr_index))
        CFG_CENTER_X:     cfg.center_x <= $signed(wr_data);
        CFG_CENTER_Y:     cfg.center_y <= $signed(wr_data);
        CFG_RADIUS:       cfg.radius   <= wr_data[RADI_W-1:0];
        CFG_IMAGE_WIDTH:  cfg.width    <= wr_data;
        CFG_IMAGE_HEIGHT: cfg.height   <= wr_data;
        default: ;
      endcase
    end
  end

  fcrs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .row_index  (row_index),
    .push       (push),
    .push_data  (push_data),
    .queue_full (queue_full)
  );

  fcrs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (queue_empty)
  );

  fcrs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .image_width (cfg.width),
    .pop_data    (pop_data),
    .empty       (queue_empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .row_hit     (row_hit),
    .span_first  (span_first),
    .span_last   (span_last)
  );

endmodule

// ----- tb/filled_circle_row_span_tb.sv -----
// Self-checking testbench for filled_circle_row_span: a directed table, then random
// circle settings and row requests, checked against a scanline span predictor.
// Depends on fcrs_pkg and the filled_circle_row_span RTL.

module filled_circle_row_span_tb;
  import fcrs_pkg::*;

  localparam int MAX_IDLE      = 17;
  localparam int LONG_HOLD     = 64;
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_ITEMS  = 1750;
  localparam int N_STEPS       = 40;

  typedef struct packed {
    logic             hit;
    logic [ROW_W-1:0] first;
    logic [ROW_W-1:0] last;
  } span_t;

  typedef enum logic {STEP_WRITE, STEP_ROW} step_kind_t;

  typedef struct packed {
    step_kind_t       kind;
    cfg_index_t       index;
    logic [DIM_W-1:0] data;
    logic [ROW_W-1:0] row;
    logic             typed;
    span_t            want;
  } plan_step_t;

  localparam span_t NO_SPAN = '{1'b0, 12'd0, 12'd0};

  // Untyped rows take their expectation from the predictor.
  localparam plan_step_t DIRECTED_PLAN [N_STEPS] = '{
    '{STEP_ROW,   CFG_CENTER_X,     13'd0,     12'd240,  1'b1, '{1'b1, 12'd320, 12'd320}},
    '{STEP_ROW,   CFG_CENTER_X,     13'd0,     12'd0,    1'b1, NO_SPAN},
    '{STEP_ROW,   CFG_CENTER_X,     13'd0,     12'd4095, 1'b1, NO_SPAN},
    '{STEP_WRITE, CFG_RADIUS,       13'd4095,  12'd0,    1'b0, NO_SPAN},
    '{STEP_ROW,   CFG_CENTER_X,     13'd0,     12'd0,    1'b1, '{1'b1, 12'd0, 12'd639}},
    '{STEP_ROW,   CFG_CENTER_X,     13'd0,     12'd479,  1'b1, '{1'b1, 12'd0, 12'd639}},
    '{STEP_ROW,   CFG_CENTER_X,     13'd0,     12'd480,  1'b1, NO_SPAN},
    '{STEP_WRITE, CFG_IMAGE_WIDTH,  13'd0,     12'd0,    1'b0, NO_SPAN},
    '{STEP_ROW,   CFG_CENTER_X,     13'd0,     12'd240,  1'b1, NO_SPAN},
    '{STEP_WRITE, CFG_IMAGE_WIDTH,  13'd8191,  12'd0,    1'b0, NO_SPAN},
    '{STEP_ROW,   CFG_CENTER_X,     13'd0,     12'd240,  1'b1, '{1'b1, 12'd0, 12'd4095}},
    '{STEP_WRITE, CFG_IMAGE_HEIGHT, 13'd0,     12'd0,    1'b0, NO_SPAN},
    '{STEP_ROW,   CFG_CENTER_X,     13'd0,     12'd0,    1'b1, NO_SPAN},
    '{STEP_WRITE, CFG_IMAGE_HEIGHT, 13'd8191,  12'd0,    1'b0, NO_SPAN},
    '{STEP_ROW,   CFG_CENTER_X,     13'd0,     12'd4095, 1'b0, NO_SPAN},
    '{STEP_ROW,   CFG_CENTER_X,     13'd0,     12'd0,    1'b0, NO_SPAN},
    '{STEP_WRITE, CFG_CENTER_X,     13'h1000,  12'd0,    1'b0, NO_SPAN},
    '{STEP_WRITE, CFG_CENTER_Y,     13'h0FFF,  12'd0,    1'b0, NO_SPAN},
    '{STEP_WRITE, CFG_RADIUS,       13'd10,    12'd0,    1'b0, NO_SPAN},
    '{STEP_WRITE, CFG_IMAGE_WIDTH,  13'd640,   12'd0,    1'b0, NO_SPAN},
    '{STEP_WRITE, CFG_IMAGE_HEIGHT, 13'd480,   12'd0,    1'b0, NO_SPAN},
    '{STEP_ROW,   CFG_CENTER_X,     13'd0,     12'd4095, 1'b1, NO_SPAN},
    '{STEP_WRITE, CFG_CENTER_Y,     13'd0,     12'd0,    1'b0, NO_SPAN},
    '{STEP_ROW,   CFG_CENTER_X,     13'd0,     12'd240,  1'b1, NO_SPAN},
    '{STEP_WRITE, CFG_CENTER_X,     13'h0FFF,  12'd0,    1'b0, NO_SPAN},
    '{STEP_ROW,   CFG_CENTER_X,     13'd0,     12'd240,  1'b1, NO_SPAN},
    '{STEP_WRITE, CFG_CENTER_X,     13'd0,     12'd0,    1'b0, NO_SPAN},
    '{STEP_WRITE, CFG_IMAGE_HEIGHT, 13'd481,   12'd0,    1'b0, NO_SPAN},
    '{STEP_WRITE, CFG_RADIUS,       13'd2,     12'd0,    1'b0, NO_SPAN},
    '{STEP_ROW,   CFG_CENTER_X,     13'd0,     12'd243,  1'b1, NO_SPAN},
    '{STEP_ROW,   CFG_CENTER_X,     13'd0,     12'd239,  1'b0, NO_SPAN},
    '{STEP_ROW,   CFG_CENTER_X,     13'd0,     12'd240,  1'b0, NO_SPAN},
    '{STEP_WRITE, CFG_RADIUS,       13'd240,   12'd0,    1'b0, NO_SPAN},
    '{STEP_ROW,   CFG_CENTER_X,     13'd0,     12'd481,  1'b1, NO_SPAN},
    '{STEP_ROW,   CFG_CENTER_X,     13'd0,     12'd480,  1'b0, NO_SPAN},
    '{STEP_WRITE, CFG_IMAGE_WIDTH,  13'd641,   12'd0,    1'b0, NO_SPAN},
    '{STEP_WRITE, CFG_RADIUS,       13'd0,     12'd0,    1'b0, NO_SPAN},
    '{STEP_WRITE, CFG_IMAGE_HEIGHT, 13'd480,   12'd0,    1'b0, NO_SPAN},
    '{STEP_ROW,   CFG_CENTER_X,     13'd0,     12'd240,  1'b1, '{1'b1, 12'd321, 12'd321}},
    '{STEP_ROW,   CFG_CENTER_X,     13'd0,     12'd239,  1'b1, NO_SPAN}
  };

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             wr_en = 1'b0;
  cfg_index_t       wr_index = CFG_CENTER_X;
  logic [DIM_W-1:0] wr_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [ROW_W-1:0] row_index = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             row_hit;
  logic [ROW_W-1:0] span_first;
  logic [ROW_W-1:0] span_last;

  // Register copies seen by the predictor
  logic signed [DIM_W-1:0] cfg_cx = '0;
  logic signed [DIM_W-1:0] cfg_cy = '0;
  logic [RADI_W-1:0]       cfg_radius = '0;
  logic [DIM_W-1:0]        cfg_width = 13'd640;
  logic [DIM_W-1:0]        cfg_height = 13'd480;

  span_t pending_spans [$];
  int    mismatch_count = 0;
  int    sender_gap_max = MAX_IDLE;
  int    receiver_stall_max = MAX_IDLE;
  bit    hold_off_request = 1'b0;

  filled_circle_row_span DUT (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .row_index  (row_index),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .row_hit    (row_hit),
    .span_first (span_first),
    .span_last  (span_last)
  );

  always #5 clk = ~clk;

  function automatic longint clip_dim(input logic [DIM_W-1:0] v);
    longint d;
    d = longint'(v);
    if (d > 4096) d = 4096;
    return d;
  endfunction

  function automatic longint halve_floor(input longint v);
    return (v >= 0) ? v / 2 : -((1 - v) / 2);
  endfunction

  // Half of n rounded, ties away from zero
  function automatic longint halve_round(input longint n);
    return (n >= 0) ? (n + 1) / 2 : -((1 - n) / 2);
  endfunction

  // round((a +/- sqrt(d)) / 2) exactly, ties away from zero
  function automatic longint span_edge(input longint a, input bit upper, input longint d);
    longint q, t, inexact;
    q = 0;
    for (int b = 15; b >= 0; b--) begin
      t = q | (longint'(1) << b);
      if (t * t <= d) q = t;
    end
    inexact = (q * q != d) ? 1 : 0;
    if (upper) begin
      if (a >= 0 || d >= a * a) return halve_floor(a + 1 + q);
      return -halve_floor(1 - a - q - inexact);
    end
    if (a >= 0 && a * a >= d) return halve_floor(a + 1 - q - inexact);
    return -halve_floor(1 - a + q);
  endfunction

  function automatic span_t predict_span(input logic [ROW_W-1:0] row);
    longint w, h, r, y, x2, y2, lo2, hi2, top, bot, dy, rad, first, last;
    span_t  s;
    w   = clip_dim(cfg_width);
    h   = clip_dim(cfg_height);
    r   = longint'(cfg_radius);
    y   = longint'(row);
    x2  = 2 * longint'(cfg_cx) + w;
    y2  = 2 * longint'(cfg_cy) + h;
    lo2 = y2 - 2 * r;
    hi2 = y2 + 2 * r;
    top = (lo2 > 0) ? halve_round(lo2) : 0;
    bot = (hi2 < 2 * h) ? halve_round(hi2) : h - 1;
    if (bot > h - 1) bot = h - 1;
    s = NO_SPAN;
    if (y >= top && y <= bot) begin
      dy  = 2 * y - y2;
      rad = 4 * r * r - dy * dy;
      if (rad >= 0) begin
        first = span_edge(x2, 1'b0, rad);
        last  = span_edge(x2, 1'b1, rad);
        if (first < 0) first = 0;
        if (last >= w) last = w - 1;
        if (first <= last) s = '{1'b1, first[ROW_W-1:0], last[ROW_W-1:0]};
      end
    end
    return s;
  endfunction

  // Mostly rows around the circle's band, some anywhere
  function automatic logic [ROW_W-1:0] pick_row();
    longint           h, r, mid, off;
    int               sel;
    logic [ROW_W-1:0] row;
    sel = $urandom_range(99, 0);
    h   = clip_dim(cfg_height);
    r   = longint'(cfg_radius);
    if (sel < 15 || h == 0) return ROW_W'($urandom_range(4095, 0));
    if (sel < 30) return ROW_W'($urandom_range(int'(h - 1), 0));
    mid = (h + 2 * longint'(cfg_cy)) / 2;
    off = $urandom_range(int'(2 * r + 6), 0);
    row = ROW_W'(mid + off - (r + 3));
    return row;
  endfunction

  function automatic logic [DIM_W-1:0] pick_offset();
    if ($urandom_range(99, 0) < 70) return 13'($urandom_range(800, 0)) - 13'd400;
    return DIM_W'($urandom_range(8191, 0));
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    int sel;
    sel = $urandom_range(99, 0);
    if (sel < 65) return DIM_W'($urandom_range(800, 16));
    if (sel < 80) return DIM_W'($urandom_range(15, 0));
    if (sel < 92) return DIM_W'($urandom_range(4096, 801));
    return DIM_W'($urandom_range(8191, 4097));
  endfunction

  function automatic logic [DIM_W-1:0] pick_radius();
    int               sel;
    logic [RADI_W-1:0] r;
    sel = $urandom_range(99, 0);
    if (sel < 60) r = RADI_W'($urandom_range(200, 0));
    else if (sel < 85) r = RADI_W'($urandom_range(4095, 0));
    else r = RADI_W'($urandom_range(4095, 4000));
    // bit 12 is not part of the radius register
    return {1'($urandom_range(1, 0)), r};
  endfunction

  task automatic write_reg(input cfg_index_t index, input logic [DIM_W-1:0] data);
    wr_en    <= 1'b1;
    wr_index <= index;
    wr_data  <= data;
    @(posedge clk);
    wr_en <= 1'b0;
    case (index)
      CFG_CENTER_X:     cfg_cx = data;
      CFG_CENTER_Y:     cfg_cy = data;
      CFG_RADIUS:       cfg_radius = data[RADI_W-1:0];
      CFG_IMAGE_WIDTH:  cfg_width = data;
      CFG_IMAGE_HEIGHT: cfg_height = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic choose_setting(input bit write_all);
    if (write_all || $urandom_range(3, 0) != 0) write_reg(CFG_CENTER_X, pick_offset());
    if (write_all || $urandom_range(3, 0) != 0) write_reg(CFG_CENTER_Y, pick_offset());
    if (write_all || $urandom_range(3, 0) != 0) write_reg(CFG_RADIUS, pick_radius());
    if (write_all || $urandom_range(3, 0) != 0) write_reg(CFG_IMAGE_WIDTH, pick_dim());
    if (write_all || $urandom_range(3, 0) != 0) write_reg(CFG_IMAGE_HEIGHT, pick_dim());
  endtask

  task automatic send_row(input logic [ROW_W-1:0] row, input span_t want);
    int gap;
    gap = $urandom_range(sender_gap_max, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    row_index <= row;
    do @(posedge clk); while (in_stall);
    pending_spans.push_back(want);
  endtask

  // Stop sending, wait for every span, then let the pipe settle
  task automatic drain_spans();
    in_valid <= 1'b0;
    while (pending_spans.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : result_sink
    int hold;
    forever begin
      if (hold_off_request) begin
        hold = LONG_HOLD;
        hold_off_request = 1'b0;
      end else begin
        hold = $urandom_range(receiver_stall_max, 0);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  always @(posedge clk) begin
    span_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_spans.size() == 0) begin
        $display("%0t: unexpected span, expected none, got hit %0d first %0d last %0d",
                 $time, row_hit, span_first, span_last);
        mismatch_count++;
      end else begin
        want = pending_spans.pop_front();
        if (row_hit !== want.hit) begin
          $display("%0t: row_hit expected %0d, got %0d", $time, want.hit, row_hit);
          mismatch_count++;
        end
        if (span_first !== want.first) begin
          $display("%0t: span_first expected %0d, got %0d", $time, want.first, span_first);
          mismatch_count++;
        end
        if (span_last !== want.last) begin
          $display("%0t: span_last expected %0d, got %0d", $time, want.last, span_last);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : stimulus
    int               sent, batch, phase;
    span_t            want;
    logic [ROW_W-1:0] row;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < N_STEPS; i++) begin
      if (DIRECTED_PLAN[i].kind == STEP_WRITE) begin
        drain_spans();
        write_reg(DIRECTED_PLAN[i].index, DIRECTED_PLAN[i].data);
      end else begin
        want = DIRECTED_PLAN[i].typed ? DIRECTED_PLAN[i].want
                                      : predict_span(DIRECTED_PLAN[i].row);
        send_row(DIRECTED_PLAN[i].row, want);
      end
    end
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      drain_spans();
      choose_setting(phase == 0);
      sender_gap_max     = $urandom_range(1, 0) ? MAX_IDLE : 0;
      receiver_stall_max = $urandom_range(1, 0) ? MAX_IDLE : 0;
      batch = $urandom_range(90, 20);
      // back the block up: long sink hold while rows keep coming
      if (phase == 2) begin
        sender_gap_max   = 0;
        hold_off_request = 1'b1;
        batch = 80;
      end
      repeat (batch) begin
        row = pick_row();
        send_row(row, predict_span(row));
      end
      sent += batch;
      phase++;
    end
    drain_spans();
    if (mismatch_count == 0 && pending_spans.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/fcrs_pkg.sv
rtl/core/fcrs_front.sv
rtl/core/fcrs_queue.sv
rtl/core/fcrs_back.sv
rtl/core/filled_circle_row_span.sv
tb/filled_circle_row_span_tb.sv
